@@ sv/ptc_pkg.sv @@
package ptc_pkg;

   // default sizes of the rule table
   localparam int DEF_NUM_MAPS        = 4;
   localparam int DEF_MAX_TILES       = 16;
   localparam int DEF_MAX_CONSTRAINTS = 4;

   // slot field width and the number of slots it can address
   localparam int SLOT_W     = 4;
   localparam int SLOT_SPAN  = 16;
   localparam int MAP_W      = 2;
   localparam int MAP_SPAN   = 4;
   localparam int VALUE_W    = 16;
   localparam int CODE_W     = 5;
   localparam int STATUS_W   = 2;

   localparam logic [CODE_W-1:0]   NO_TILE_CODE     = 5'd16;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDEFINED = 2'd2;

   typedef enum logic [1:0] {
      ACT_CLASSIFY = 2'd0,
      ACT_DEFINE   = 2'd1,
      ACT_APPEND   = 2'd2,
      ACT_DELETE   = 2'd3
   } action_type;

   // one stored constraint
   typedef struct packed {
      logic [MAP_W-1:0]          map;
      logic                      at_least;
      logic signed [VALUE_W-1:0] limit;
   } rule_term_type;

   // update of the per-slot valid bit and count
   typedef struct packed {
      logic              set_tile;
      logic              clr_tile;
      logic              inc_count;
      logic [SLOT_W-1:0] slot;
   } tbl_update_type;

endpackage

@@ sv/priority_threshold_tile_classifier.sv @@
// First-match tile rule classifier.
// Request channel: an item is taken on a rising edge with start high and busy
// low. req_action selects classify, define, append or delete; the other req_
// fields carry the slot, the constraint and the four noise values.
// Response channel: one beat per item, rsp_valid high for exactly one cycle
// with rsp_tile_code and rsp_status. The receiver cannot stall; busy stays
// high until the response beat is shown, and a new request may be taken in
// the same cycle as that beat.
// Define, append and delete are done in ST_EXEC, which registers the answer.
// Classify walks the rules in slot order through the constraint memory,
// one constraint read per cycle (registered read, next read issued while
// the previous one is checked) except where it passes over an undefined
// slot or drops the rest of a failed rule, and it stops at the first rule
// that matches.
// One item is in work at a time.
// Reset clears all slots (no rules defined) and aborts any item in work;
// the constraint memory is not cleared, only written entries are ever read.
module priority_threshold_tile_classifier
   import ptc_pkg::*;
#(
   parameter int NUM_MAPS        = DEF_NUM_MAPS,
   parameter int MAX_TILES       = DEF_MAX_TILES,
   parameter int MAX_CONSTRAINTS = DEF_MAX_CONSTRAINTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic [SLOT_W-1:0]         req_tile_slot,
   input  logic [MAP_W-1:0]          req_map_select,
   input  logic                      req_compare_at_least,
   input  logic signed [VALUE_W-1:0] req_threshold,
   input  logic signed [VALUE_W-1:0] req_noise_value_0,
   input  logic signed [VALUE_W-1:0] req_noise_value_1,
   input  logic signed [VALUE_W-1:0] req_noise_value_2,
   input  logic signed [VALUE_W-1:0] req_noise_value_3,
   output logic                      rsp_valid,
   output logic [CODE_W-1:0]         rsp_tile_code,
   output logic [STATUS_W-1:0]       rsp_status
);

   // only slots the slot field can address take part
   localparam int NT      = (MAX_TILES < SLOT_SPAN) ? MAX_TILES : SLOT_SPAN;
   localparam int MC      = MAX_CONSTRAINTS;
   localparam int TILE_W  = $clog2(NT);
   localparam int S_W     = $clog2(NT + 1);
   localparam int K_W     = (MC > 1) ? $clog2(MC) : 1;
   localparam int CNT_W   = $clog2(MC + 1);
   localparam int DEPTH   = NT * MC;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MAP_LIM = (NUM_MAPS < MAP_SPAN) ? NUM_MAPS : MAP_SPAN;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // captured request
   action_type                act_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [MAP_W-1:0]          map_ff;
   logic                      atl_ff;
   logic signed [VALUE_W-1:0] thr_ff;
   logic signed [VALUE_W-1:0] cell_ff [MAP_SPAN];

   // scan pointer and the read in flight
   logic [S_W-1:0]    s_ff, s_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [TILE_W-1:0] chk_tile_ff, chk_tile_in;
   logic              chk_last_ff, chk_last_in;

   // response
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic              accept;
   tbl_update_type    upd;
   logic [SLOT_W-1:0] tbl_rd_slot;
   logic              tbl_valid;
   logic [CNT_W-1:0]  tbl_count;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   rule_term_type mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   rule_term_type mem_rd_data;

   logic signed [VALUE_W-1:0] term_value;
   logic                      term_pass;
   logic                      slot_in_range;
   logic                      s_end;
   logic                      same_tile;
   logic [TILE_W-1:0]         s_idx;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign s_idx         = s_ff[TILE_W-1:0];
   assign s_end         = (s_ff == S_W'(NT));
   assign same_tile     = !s_end && (s_idx == chk_tile_ff);
   assign slot_in_range = ({1'b0, slot_ff} < (SLOT_W + 1)'(NT));

   // one table read port: scan pointer while scanning, else request slot
   assign tbl_rd_slot = (state_ff == ST_SCAN) ? SLOT_W'(s_idx) : slot_ff;

   ptc_table #(
      .NUM_TILES (NT),
      .CNT_W     (CNT_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rd_slot  (tbl_rd_slot),
      .rd_valid (tbl_valid),
      .rd_count (tbl_count)
   );

   ptc_rule_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // append address: slot row, next free entry
   assign mem_wr_addr = AW'(slot_ff[TILE_W-1:0]) * AW'(MC) + AW'(tbl_count);
   assign mem_wr_data = '{map: map_ff, at_least: atl_ff, limit: thr_ff};
   assign mem_rd_addr = AW'(s_idx) * AW'(MC) + AW'(k_ff);

   // check the constraint that came back from memory
   always_comb begin
      if ({1'b0, mem_rd_data.map} < (MAP_W + 1)'(MAP_LIM)) begin
         term_value = cell_ff[mem_rd_data.map];
      end else begin
         term_value = '0;
      end
      if (mem_rd_data.at_least) begin
         term_pass = (term_value >= mem_rd_data.limit);
      end else begin
         term_pass = (term_value <= mem_rd_data.limit);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      s_in          = s_ff;
      k_in          = k_ff;
      chk_vld_in    = 1'b0;
      chk_tile_in   = chk_tile_ff;
      chk_last_in   = chk_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_code_in   = rsp_code_ff;
      rsp_status_in = rsp_status_ff;
      upd           = '{set_tile: 1'b0, clr_tile: 1'b0, inc_count: 1'b0, slot: slot_ff};
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in = '0;
               k_in = '0;
               if (action_type'(req_action) == ACT_CLASSIFY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_code_in   = CODE_W'(slot_ff);
            rsp_status_in = STATUS_OK;
            if (!slot_in_range) begin
               rsp_status_in = STATUS_UNDEFINED;
            end else begin
               case (act_ff)
                  ACT_DEFINE: begin
                     upd.set_tile = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (!tbl_valid) begin
                        rsp_status_in = STATUS_UNDEFINED;
                     end else if (tbl_count >= CNT_W'(MC)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en     = 1'b1;
                        upd.inc_count = 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (!tbl_valid) begin
                        rsp_status_in = STATUS_UNDEFINED;
                     end else begin
                        upd.clr_tile = 1'b1;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rsp_status_in = STATUS_OK;
            rsp_code_in   = NO_TILE_CODE;
            if (chk_vld_ff && term_pass && chk_last_ff) begin
               // last constraint of the pending rule holds
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_code_in  = CODE_W'(chk_tile_ff);
            end else if (chk_vld_ff && !term_pass && same_tile) begin
               // rule failed: drop the rest of it
               s_in = s_ff + S_W'(1);
               k_in = '0;
            end else if (s_end) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else if (!tbl_valid) begin
               s_in = s_ff + S_W'(1);
               k_in = '0;
            end else if (tbl_count == '0) begin
               // empty rule always matches
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_code_in  = CODE_W'(s_idx);
            end else begin
               mem_rd_en   = 1'b1;
               chk_vld_in  = 1'b1;
               chk_tile_in = s_idx;
               chk_last_in = ((CNT_W'(k_ff) + CNT_W'(1)) == tbl_count);
               if (chk_last_in) begin
                  s_in = s_ff + S_W'(1);
                  k_in = '0;
               end else begin
                  k_in = k_ff + K_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and pointer registers
   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      k_ff          <= k_in;
      chk_tile_ff   <= chk_tile_in;
      chk_last_ff   <= chk_last_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         act_ff     <= action_type'(req_action);
         slot_ff    <= req_tile_slot;
         map_ff     <= req_map_select;
         atl_ff     <= req_compare_at_least;
         thr_ff     <= req_threshold;
         cell_ff[0] <= req_noise_value_0;
         cell_ff[1] <= req_noise_value_1;
         cell_ff[2] <= req_noise_value_2;
         cell_ff[3] <= req_noise_value_3;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tile_code = rsp_code_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ sv/ptc_rule_mem.sv @@
module ptc_rule_mem
   import ptc_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_TILES * DEF_MAX_CONSTRAINTS,
   parameter int AW    = $clog2(DEF_MAX_TILES * DEF_MAX_CONSTRAINTS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rule_term_type wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output rule_term_type rd_data
);

   rule_term_type mem [DEPTH];
   rule_term_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ptc_table.sv @@
module ptc_table
   import ptc_pkg::*;
#(
   parameter int NUM_TILES = DEF_MAX_TILES,
   parameter int CNT_W     = $clog2(DEF_MAX_CONSTRAINTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_update_type    upd,
   input  logic [SLOT_W-1:0] rd_slot,
   output logic              rd_valid,
   output logic [CNT_W-1:0]  rd_count
);

   localparam int TILE_W = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;

   logic [NUM_TILES-1:0] valid_ff;
   logic [CNT_W-1:0]     count_ff [NUM_TILES];
   logic [TILE_W-1:0]    wr_idx;
   logic [TILE_W-1:0]    rd_idx;

   assign wr_idx = upd.slot[TILE_W-1:0];
   assign rd_idx = rd_slot[TILE_W-1:0];

   // per-slot valid bit and constraint count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_TILES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (upd.set_tile) begin
         valid_ff[wr_idx] <= 1'b1;
         count_ff[wr_idx] <= '0;
      end else if (upd.clr_tile) begin
         valid_ff[wr_idx] <= 1'b0;
         count_ff[wr_idx] <= '0;
      end else if (upd.inc_count) begin
         count_ff[wr_idx] <= count_ff[wr_idx] + CNT_W'(1);
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_count = count_ff[rd_idx];

endmodule

@@ verif/tb_priority_threshold_tile_classifier.sv @@
`timescale 1ns / 1ps

module tb_priority_threshold_tile_classifier;
   import ptc_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 80;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [STATUS_W-1:0] status;
   } tile_answer_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_action;
   logic [SLOT_W-1:0]         req_tile_slot;
   logic [MAP_W-1:0]          req_map_select;
   logic                      req_compare_at_least;
   logic signed [VALUE_W-1:0] req_threshold;
   logic signed [VALUE_W-1:0] req_noise_value_0;
   logic signed [VALUE_W-1:0] req_noise_value_1;
   logic signed [VALUE_W-1:0] req_noise_value_2;
   logic signed [VALUE_W-1:0] req_noise_value_3;
   logic                      rsp_valid;
   logic [CODE_W-1:0]         rsp_tile_code;
   logic [STATUS_W-1:0]       rsp_status;

   // rule table as the block should hold it
   logic          rule_valid [SLOT_SPAN];
   int unsigned   rule_len   [SLOT_SPAN];
   rule_term_type rule_terms [SLOT_SPAN][DEF_MAX_CONSTRAINTS];

   tile_answer_type           pending_answers[$];
   tile_answer_type           oldest_answer;
   tile_answer_type           expected_answer;
   int                        fail_count;
   int                        stall_cycles;
   bit                        gaps_enabled;
   logic signed [VALUE_W-1:0] threshold_pool [8];

   priority_threshold_tile_classifier u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_tile_slot        (req_tile_slot),
      .req_map_select       (req_map_select),
      .req_compare_at_least (req_compare_at_least),
      .req_threshold        (req_threshold),
      .req_noise_value_0    (req_noise_value_0),
      .req_noise_value_1    (req_noise_value_1),
      .req_noise_value_2    (req_noise_value_2),
      .req_noise_value_3    (req_noise_value_3),
      .rsp_valid            (rsp_valid),
      .rsp_tile_code        (rsp_tile_code),
      .rsp_status           (rsp_status)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // applies one request to the rule table and returns the answer it should get
   function automatic tile_answer_type predict_tile_answer(
      input action_type                act,
      input logic [SLOT_W-1:0]         slot,
      input rule_term_type             term,
      input logic signed [VALUE_W-1:0] n0,
      input logic signed [VALUE_W-1:0] n1,
      input logic signed [VALUE_W-1:0] n2,
      input logic signed [VALUE_W-1:0] n3
   );
      tile_answer_type           ans;
      logic signed [VALUE_W-1:0] noise [MAP_SPAN];
      logic signed [VALUE_W-1:0] v;
      logic signed [VALUE_W-1:0] lim;
      rule_term_type             t;
      bit                        found;
      bit                        holds;
      ans.code   = CODE_W'(slot);
      ans.status = STATUS_OK;
      noise[0] = n0;
      noise[1] = n1;
      noise[2] = n2;
      noise[3] = n3;
      case (act)
         ACT_CLASSIFY: begin
            // first valid rule, lowest slot, whose terms all hold
            ans.code = NO_TILE_CODE;
            found    = 1'b0;
            for (int s = 0; s < SLOT_SPAN; s++) begin
               if (!found && rule_valid[s]) begin
                  holds = 1'b1;
                  for (int unsigned k = 0; k < rule_len[s]; k++) begin
                     t   = rule_terms[s][k];
                     lim = t.limit;
                     v   = (t.map < DEF_NUM_MAPS) ? noise[t.map] : '0;
                     if (t.at_least ? (v < lim) : (v > lim))
                        holds = 1'b0;
                  end
                  if (holds) begin
                     found    = 1'b1;
                     ans.code = CODE_W'(s);
                  end
               end
            end
         end
         ACT_DEFINE: begin
            rule_valid[slot] = 1'b1;
            rule_len[slot]   = 0;
         end
         ACT_APPEND: begin
            if (!rule_valid[slot]) begin
               ans.status = STATUS_UNDEFINED;
            end else if (rule_len[slot] >= DEF_MAX_CONSTRAINTS) begin
               ans.status = STATUS_FULL;
            end else begin
               rule_terms[slot][rule_len[slot]] = term;
               rule_len[slot]++;
            end
         end
         default: begin
            if (!rule_valid[slot]) begin
               ans.status = STATUS_UNDEFINED;
            end else begin
               rule_valid[slot] = 1'b0;
               rule_len[slot]   = 0;
            end
         end
      endcase
      return ans;
   endfunction

   // check each response beat, then log each accepted request beat
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_SPAN; s++) begin
            rule_valid[s] = 1'b0;
            rule_len[s]   = 0;
         end
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $error("response beat with no request pending: code %0d status %0d",
                      rsp_tile_code, rsp_status);
               fail_count++;
            end else begin
               oldest_answer = pending_answers.pop_front();
               if (rsp_tile_code !== oldest_answer.code) begin
                  $error("rsp_tile_code mismatch: expected %0d, actual %0d",
                         oldest_answer.code, rsp_tile_code);
                  fail_count++;
               end
               if (rsp_status !== oldest_answer.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         oldest_answer.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_answer = predict_tile_answer(
               action_type'(req_action), req_tile_slot,
               '{map: req_map_select, at_least: req_compare_at_least,
                 limit: req_threshold},
               req_noise_value_0, req_noise_value_1,
               req_noise_value_2, req_noise_value_3);
            pending_answers.insert(pending_answers.size(), expected_answer);
         end
         // watchdog on cycles with no beat either way
         if (rsp_valid || (start && !busy))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // drive one request beat and hold it until the block takes it
   task automatic send_beat(
      input action_type                act,
      input logic [SLOT_W-1:0]         slot,
      input logic [MAP_W-1:0]          map,
      input logic                      at_least,
      input logic signed [VALUE_W-1:0] thr,
      input logic signed [VALUE_W-1:0] n0,
      input logic signed [VALUE_W-1:0] n1,
      input logic signed [VALUE_W-1:0] n2,
      input logic signed [VALUE_W-1:0] n3
   );
      if (gaps_enabled) begin
         while ($urandom_range(99) < 8) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start                = 1'b1;
      req_action           = act;
      req_tile_slot        = slot;
      req_map_select       = map;
      req_compare_at_least = at_least;
      req_threshold        = thr;
      req_noise_value_0    = n0;
      req_noise_value_1    = n1;
      req_noise_value_2    = n2;
      req_noise_value_3    = n3;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic define_rule(input logic [SLOT_W-1:0] slot);
      send_beat(ACT_DEFINE, slot, MAP_W'($urandom), 1'($urandom), VALUE_W'($urandom),
                VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                VALUE_W'($urandom));
   endtask

   task automatic append_term(input logic [SLOT_W-1:0] slot, input logic [MAP_W-1:0] map,
                              input logic at_least, input logic signed [VALUE_W-1:0] thr);
      send_beat(ACT_APPEND, slot, map, at_least, thr,
                VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                VALUE_W'($urandom));
   endtask

   task automatic delete_rule(input logic [SLOT_W-1:0] slot);
      send_beat(ACT_DELETE, slot, MAP_W'($urandom), 1'($urandom), VALUE_W'($urandom),
                VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                VALUE_W'($urandom));
   endtask

   task automatic classify_cell(input logic signed [VALUE_W-1:0] n0,
                                input logic signed [VALUE_W-1:0] n1,
                                input logic signed [VALUE_W-1:0] n2,
                                input logic signed [VALUE_W-1:0] n3);
      send_beat(ACT_CLASSIFY, SLOT_W'($urandom), MAP_W'($urandom), 1'($urandom),
                VALUE_W'($urandom), n0, n1, n2, n3);
   endtask

   // stop sending until every answer is back
   task automatic wait_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // mostly near stored thresholds, some extremes and plain random values
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(9);
      case (r)
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3, 4: return VALUE_W'($urandom);
         default: return VALUE_W'(threshold_pool[$urandom_range(7)]
                                  + $signed($urandom_range(2)) - 1);
      endcase
   endfunction

   // nothing defined, edits of undefined slots
   task automatic test_empty_table();
      classify_cell(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      classify_cell(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      delete_rule(4'd3);
      append_term(4'd3, 2'd1, 1'b1, 16'sh1000);
   endtask

   // define, fill, overflow, redefine and delete
   task automatic test_rule_editing();
      define_rule(4'd15);
      classify_cell(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      define_rule(4'd0);
      append_term(4'd0, 2'd0, 1'b1, 16'sh8000);
      append_term(4'd0, 2'd1, 1'b0, 16'sh7FFF);
      append_term(4'd0, 2'd2, 1'b1, 16'sh0000);
      append_term(4'd0, 2'd3, 1'b0, 16'sh0000);
      append_term(4'd0, 2'd2, 1'b0, 16'sh8000);
      // equal to threshold passes both ways
      classify_cell(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
      classify_cell(16'sh0000, 16'sh0000, 16'shFFFF, 16'sh0000);
      classify_cell(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001);
      define_rule(4'd0);
      classify_cell(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
      delete_rule(4'd0);
      delete_rule(4'd0);
      classify_cell(16'sh1234, 16'sh8765, 16'sh0FFF, 16'shF000);
      delete_rule(4'd15);
      classify_cell(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
   endtask

   // random rule churn with classifies near the thresholds in use
   task automatic test_random_traffic(input int count);
      int unsigned        pick;
      logic [SLOT_W-1:0]  slot;
      logic signed [VALUE_W-1:0] thr;
      for (int i = 0; i < count; i++) begin
         gaps_enabled = !(i >= 500 && i < 800);
         if (i % 400 == 399)
            wait_until_drained();
         pick = $urandom_range(99);
         slot = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(7)) : SLOT_W'($urandom);
         if (pick < 45) begin
            classify_cell(pick_value(), pick_value(), pick_value(), pick_value());
         end else if (pick < 60) begin
            define_rule(slot);
         end else if (pick < 88) begin
            thr = pick_value();
            threshold_pool[$urandom_range(7)] = thr;
            append_term(slot, MAP_W'($urandom), 1'($urandom), thr);
         end else begin
            delete_rule(slot);
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      start                = 1'b0;
      req_action           = ACT_CLASSIFY;
      req_tile_slot        = '0;
      req_map_select       = '0;
      req_compare_at_least = 1'b0;
      req_threshold        = '0;
      req_noise_value_0    = '0;
      req_noise_value_1    = '0;
      req_noise_value_2    = '0;
      req_noise_value_3    = '0;
      fail_count           = 0;
      gaps_enabled         = 1'b1;
      for (int i = 0; i < 8; i++)
         threshold_pool[i] = VALUE_W'($urandom);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_rule_editing();
      test_random_traffic(RANDOM_ITEMS);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d response beats never arrived", pending_answers.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
sv/ptc_pkg.sv
sv/ptc_rule_mem.sv
sv/ptc_table.sv
sv/priority_threshold_tile_classifier.sv
verif/tb_priority_threshold_tile_classifier.sv
